@@ hw/rtl/saltag_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// saltag_pkg
// Shared types, codes and defaults for the set-associative LRU tag store.
// ----------------------------------------------------------------------------
package saltag_pkg;

	localparam int DEF_MAX_SET_BITS = 6;
	localparam int DEF_MAX_WAYS     = 8;

	localparam int ADDR_W  = 64;
	localparam int STAMP_W = 64;
	localparam int COUNT_W = 32;
	localparam int CFG_AW  = 2;
	localparam int CFG_DW  = 6;

	localparam logic [CFG_AW-1:0] REG_SET_BITS    = 2'd0;
	localparam logic [CFG_AW-1:0] REG_WAYS_IN_USE = 2'd1;
	localparam logic [CFG_AW-1:0] REG_OFFSET_BITS = 2'd2;

	localparam logic [1:0] OUT_HIT   = 2'd0;
	localparam logic [1:0] OUT_FILL  = 2'd1;
	localparam logic [1:0] OUT_EVICT = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              mode;
	} access_t;

	typedef struct packed {
		logic [1:0]         outcome;
		logic               last;
		logic [COUNT_W-1:0] hits_so_far;
		logic [COUNT_W-1:0] misses_so_far;
		logic [COUNT_W-1:0] evictions_so_far;
	} result_t;

	typedef struct packed {
		logic               valid;
		logic [ADDR_W-1:0]  tag;
		logic [STAMP_W-1:0] stamp;
	} line_t;

	typedef struct packed {
		logic load;
		logic issue;
		logic lookup;
		logic scan;
		logic commit;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic found;
		logic multi_way;
		logic scan_done;
	} status_t;

endpackage

`default_nettype wire

@@ hw/rtl/saltag_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// saltag_ctrl
// Sequencer: decode, row read, lookup, LRU scan and row write per access.
// ----------------------------------------------------------------------------
module saltag_ctrl import saltag_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire logic    mode,
	input  wire status_t status,
	output cmd_t         cmd,
	output logic         busy
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECODE = 5'b00010,
		S_LOOKUP = 5'b00100,
		S_SCAN   = 5'b01000,
		S_COMMIT = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   mode_q;
	logic   second_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.last = !mode_q || second_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.issue = 1'b1;
				state_d   = S_LOOKUP;
			end
			S_LOOKUP: begin
				cmd.lookup = 1'b1;
				if (status.found || !status.multi_way) begin
					state_d = S_COMMIT;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_done) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = cmd.last ? S_IDLE : S_DECODE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mode_q   <= 1'b0;
			second_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				mode_q   <= mode;
				second_q <= 1'b0;
			end else if (cmd.commit) begin
				second_q <= 1'b1;
			end
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/saltag_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// saltag_dp
// Datapath: configuration, address split, set memory, compare, LRU search,
// counters and result register.
// ----------------------------------------------------------------------------
module saltag_dp import saltag_pkg::*; #(
	parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
	parameter int MAX_WAYS     = DEF_MAX_WAYS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_AW-1:0] cfg_addr,
	input  wire logic [CFG_DW-1:0] cfg_wdata,
	input  wire access_t           access,
	input  wire cmd_t              cmd,
	output status_t                status,
	output logic                   done,
	output result_t                result
);

	localparam int SETS = 1 << MAX_SET_BITS;
	localparam int SW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WCW  = $clog2(MAX_WAYS + 1);

	logic [2:0] set_bits_q;
	logic [3:0] ways_in_use_q;
	logic [5:0] offset_bits_q;

	logic [ADDR_W-1:0]  addr_q;
	logic [SW-1:0]      set_q;
	logic [ADDR_W-1:0]  tag_q;
	logic [STAMP_W-1:0] clock_q;
	logic [COUNT_W-1:0] hits_q, misses_q, evicts_q;

	line_t [MAX_WAYS-1:0] line_mem [SETS];
	logic  [SETS-1:0]     row_init_q;
	line_t [MAX_WAYS-1:0] rd_row_q;
	logic                 rd_init_q;

	logic [WW-1:0]      way_q;
	logic [WW-1:0]      idx_q;
	logic [1:0]         kind_q;
	logic [STAMP_W-1:0] best_q;

	logic               done_q;
	result_t            result_q;

	logic [2:0]           sb;
	logic [WCW-1:0]       ways;
	logic [ADDR_W-1:0]    shifted;
	logic [6:0]           tag_sh;
	logic [SW-1:0]        set_d;
	logic [ADDR_W-1:0]    tag_d;
	line_t [MAX_WAYS-1:0] row_eff;
	line_t [MAX_WAYS-1:0] row_new;
	logic                 hit_any, free_any;
	logic [WW-1:0]        hit_way, free_way;
	logic [COUNT_W-1:0]   hits_d, misses_d, evicts_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q    <= 3'd0;
			ways_in_use_q <= 4'd1;
			offset_bits_q <= 6'd0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SET_BITS:    set_bits_q    <= cfg_wdata[2:0];
				REG_WAYS_IN_USE: ways_in_use_q <= cfg_wdata[3:0];
				REG_OFFSET_BITS: offset_bits_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (int'(set_bits_q) > MAX_SET_BITS) begin
			sb = 3'(MAX_SET_BITS);
		end else begin
			sb = set_bits_q;
		end
		if (ways_in_use_q == 4'd0) begin
			ways = WCW'(1);
		end else if (int'(ways_in_use_q) > MAX_WAYS) begin
			ways = WCW'(MAX_WAYS);
		end else begin
			ways = WCW'(ways_in_use_q);
		end
	end

	assign shifted = addr_q >> offset_bits_q;
	assign set_d   = shifted[SW-1:0] & ~({SW{1'b1}} << sb);
	assign tag_sh  = 7'(offset_bits_q) + 7'(sb);
	assign tag_d   = tag_sh[6] ? '0 : (addr_q >> tag_sh[5:0]);

	assign row_eff = rd_init_q ? rd_row_q : '0;

	always_comb begin
		hit_any  = 1'b0;
		free_any = 1'b0;
		hit_way  = '0;
		free_way = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (w < int'(ways)) begin
				if (row_eff[w].valid && row_eff[w].tag == tag_q) begin
					hit_any = 1'b1;
					hit_way = WW'(w);
				end
				if (!row_eff[w].valid) begin
					free_any = 1'b1;
					free_way = WW'(w);
				end
			end
		end
	end

	assign status.found     = hit_any || free_any;
	assign status.multi_way = (ways > WCW'(1));
	assign status.scan_done = (WCW'(idx_q) + WCW'(1) == ways);

	always_comb begin
		row_new               = row_eff;
		row_new[way_q].valid  = 1'b1;
		row_new[way_q].tag    = tag_q;
		row_new[way_q].stamp  = clock_q;
	end

	always_comb begin
		hits_d   = hits_q;
		misses_d = misses_q;
		evicts_d = evicts_q;
		if (kind_q == OUT_HIT) begin
			hits_d = hits_q + COUNT_W'(1);
		end else begin
			misses_d = misses_q + COUNT_W'(1);
		end
		if (kind_q == OUT_EVICT) begin
			evicts_d = evicts_q + COUNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_row_q  <= line_mem[set_d];
			rd_init_q <= row_init_q[set_d];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			line_mem[set_q] <= row_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= access.addr;
		end
		if (cmd.issue) begin
			set_q <= set_d;
			tag_q <= tag_d;
		end
		if (cmd.lookup) begin
			idx_q  <= WW'(1);
			best_q <= row_eff[0].stamp;
			if (hit_any) begin
				way_q  <= hit_way;
				kind_q <= OUT_HIT;
			end else if (free_any) begin
				way_q  <= free_way;
				kind_q <= OUT_FILL;
			end else begin
				way_q  <= '0;
				kind_q <= OUT_EVICT;
			end
		end
		if (cmd.scan) begin
			idx_q <= idx_q + WW'(1);
			if (row_eff[idx_q].stamp < best_q) begin
				best_q <= row_eff[idx_q].stamp;
				way_q  <= idx_q;
			end
		end
		if (cmd.commit) begin
			result_q.outcome          <= kind_q;
			result_q.last             <= cmd.last;
			result_q.hits_so_far      <= hits_d;
			result_q.misses_so_far    <= misses_d;
			result_q.evictions_so_far <= evicts_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_init_q <= '0;
			clock_q    <= '0;
			hits_q     <= '0;
			misses_q   <= '0;
			evicts_q   <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.commit;
			if (cmd.issue) begin
				clock_q <= clock_q + STAMP_W'(1);
			end
			if (cmd.commit) begin
				row_init_q[set_q] <= 1'b1;
				hits_q            <= hits_d;
				misses_q          <= misses_d;
				evicts_q          <= evicts_d;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

@@ hw/rtl/set_assoc_lru_cache_tag_store_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tag_store_unit
// Set-associative cache tag store with least-recently-used replacement.
//
// An item (access.addr, access.mode) is taken at a clock edge with start high
// and busy low. Mode 0 makes one access, mode 1 two accesses to the same
// address. Each access gives one result on the result port, marked by done
// for exactly one cycle; result.last is set on the final result of the item.
// The receiver cannot stall: every result must be taken as it appears.
// Per access: decode and row read, lookup, row write. A miss with more than
// one way in use, all valid, adds an LRU search before the row write, one
// stamp compare per cycle. The result strobe is registered from the row write
// and shows in the cycle after it; busy drops in the cycle that the final done
// is shown, so the next item may start then. The single-port set memory sets
// the read-modify-write sequence per access. Configuration (cfg_we, cfg_addr,
// cfg_wdata) is written by the user only while idle; the block does not
// enforce it. Index 0 set_bits, 1 ways_in_use, 2 offset_bits; other indexes
// are ignored. Reset clears the configuration, counters, access clock and all
// set rows (a per-set init flag marks rows empty); no clearing pass is needed.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tag_store_unit import saltag_pkg::*; #(
	parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
	parameter int MAX_WAYS     = DEF_MAX_WAYS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_AW-1:0] cfg_addr,
	input  wire logic [CFG_DW-1:0] cfg_wdata,
	input  wire logic              start,
	output logic                   busy,
	input  wire access_t           access,
	output logic                   done,
	output result_t                result
);

	cmd_t    cmd;
	status_t status;

	saltag_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (access.mode),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	saltag_dp #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.MAX_WAYS     (MAX_WAYS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.access    (access),
		.cmd       (cmd),
		.status    (status),
		.done      (done),
		.result    (result)
	);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results strobed in adjacent cycles");

	a_modify_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.last |-> busy)
		else $error("second access of modify not in progress");

	a_outcome_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.outcome == OUT_HIT || result.outcome == OUT_FILL ||
			result.outcome == OUT_EVICT))
		else $error("bad outcome code");

endmodule

`default_nettype wire

@@ sim/tb_set_assoc_lru_cache_tag_store_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_tag_store_unit
// Drives access items into the LRU tag store and checks every result.
// A built-in tag store tracks valid bits, tags, stamps and counters. It
// predicts each outcome and the running counts. Directed items cover single-way
// thrashing, clamped set bits and way counts, and shifts wider than the address.
// Random phases then sweep many configurations without resetting the store.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_tag_store_unit import saltag_pkg::*; ();

	localparam int LINES = (1 << DEF_MAX_SET_BITS) * DEF_MAX_WAYS;
	localparam logic [CFG_AW-1:0] REG_UNUSED = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_AW-1:0] cfg_addr;
	logic [CFG_DW-1:0] cfg_wdata;
	logic              start;
	logic              busy;
	access_t           access;
	logic              done;
	result_t           result;

	logic               line_valid [LINES];
	logic [ADDR_W-1:0]  line_tag [LINES];
	logic [STAMP_W-1:0] line_stamp [LINES];
	logic [STAMP_W-1:0] access_clock;
	logic [COUNT_W-1:0] hit_tally;
	logic [COUNT_W-1:0] miss_tally;
	logic [COUNT_W-1:0] evict_tally;
	logic [2:0]         cfg_set_bits;
	logic [3:0]         cfg_ways;
	logic [5:0]         cfg_offset_bits;

	result_t pending_results[$];
	int      idle_pct;
	logic    failed;

	set_assoc_lru_cache_tag_store_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.access(access),
		.done(done),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int eff_set_bits();
		return (cfg_set_bits > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(cfg_set_bits);
	endfunction

	function automatic int eff_ways();
		if (cfg_ways == 0)
			return 1;
		return (cfg_ways > DEF_MAX_WAYS) ? DEF_MAX_WAYS : int'(cfg_ways);
	endfunction

	function automatic logic [1:0] lookup_line(input logic [ADDR_W-1:0] addr);
		int sb;
		int ways;
		int base;
		int victim;
		logic [ADDR_W-1:0] set_idx;
		logic [ADDR_W-1:0] tag;
		logic [STAMP_W-1:0] oldest;
		sb = eff_set_bits();
		ways = eff_ways();
		access_clock = access_clock + 1'b1;
		set_idx = (addr >> cfg_offset_bits) & ((64'd1 << sb) - 64'd1);
		tag = (int'(cfg_offset_bits) + sb >= ADDR_W) ? '0 : addr >> (int'(cfg_offset_bits) + sb);
		base = int'(set_idx) * DEF_MAX_WAYS;
		for (int w = 0; w < ways; w++) begin
			if (line_valid[base + w] && line_tag[base + w] == tag) begin
				hit_tally = hit_tally + 1'b1;
				line_stamp[base + w] = access_clock;
				return OUT_HIT;
			end
		end
		miss_tally = miss_tally + 1'b1;
		for (int w = 0; w < ways; w++) begin
			if (!line_valid[base + w]) begin
				line_valid[base + w] = 1'b1;
				line_tag[base + w] = tag;
				line_stamp[base + w] = access_clock;
				return OUT_FILL;
			end
		end
		evict_tally = evict_tally + 1'b1;
		victim = 0;
		oldest = line_stamp[base];
		for (int w = 1; w < ways; w++) begin
			if (line_stamp[base + w] < oldest) begin
				oldest = line_stamp[base + w];
				victim = w;
			end
		end
		line_tag[base + victim] = tag;
		line_stamp[base + victim] = access_clock;
		return OUT_EVICT;
	endfunction

	task automatic predict_item(input access_t item);
		result_t r;
		for (int k = 0; k <= int'(item.mode); k++) begin
			r.outcome = lookup_line(item.addr);
			r.last = (k == int'(item.mode));
			r.hits_so_far = hit_tally;
			r.misses_so_far = miss_tally;
			r.evictions_so_far = evict_tally;
			pending_results.push_back(r);
		end
	endtask

	task automatic send_access(input logic [ADDR_W-1:0] addr, input logic mode);
		int gap;
		access_t item;
		item.addr = addr;
		item.mode = mode;
		gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		access <= item;
		do
			@(posedge clk);
		while (busy);
		predict_item(item);
		@(negedge clk);
	endtask

	task automatic settle_idle();
		int guard;
		guard = 0;
		start <= 1'b0;
		while ((pending_results.size() != 0 || busy) && guard < 4000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic apply_config(input logic [5:0] sb, input logic [5:0] ways, input logic [5:0] ob);
		cfg_we <= 1'b1;
		cfg_addr <= REG_SET_BITS;
		cfg_wdata <= sb;
		@(negedge clk);
		cfg_addr <= REG_WAYS_IN_USE;
		cfg_wdata <= ways;
		@(negedge clk);
		cfg_addr <= REG_OFFSET_BITS;
		cfg_wdata <= ob;
		@(negedge clk);
		cfg_addr <= REG_UNUSED;
		cfg_wdata <= CFG_DW'($urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_set_bits = sb[2:0];
		cfg_ways = ways[3:0];
		cfg_offset_bits = ob;
		@(negedge clk);
	endtask

	task automatic test_single_way();
		idle_pct = 0;
		send_access(64'd0, 1'b0);
		send_access(64'd0, 1'b0);
		send_access('1, 1'b1);
		send_access(64'd0, 1'b0);
		send_access(64'h5555_5555_5555_5555, 1'b0);
		send_access(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
	endtask

	task automatic test_way_limit();
		settle_idle();
		apply_config(6'd7, 6'd15, 6'd0);
		for (int t = 1; t <= 9; t++)
			send_access((64'(t) << 6) | 64'd5, t == 9);
		send_access((64'd2 << 6) | 64'd5, 1'b1);
		send_access((64'd1 << 6) | 64'd5, 1'b0);
	endtask

	task automatic test_wide_shifts();
		settle_idle();
		apply_config(6'd2, 6'd0, 6'd63);
		send_access(64'd0, 1'b0);
		send_access(64'h8000_0000_0000_0000, 1'b0);
		send_access('1, 1'b1);
		send_access(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
	endtask

	task automatic run_traffic_phase(input logic [5:0] sb, input logic [5:0] ways,
			input logic [5:0] ob, input int pct, input int count);
		int sb_eff;
		int ways_eff;
		int sh;
		logic [ADDR_W-1:0] tag_base;
		logic [ADDR_W-1:0] offset_mask;
		logic [ADDR_W-1:0] tag_val;
		logic [ADDR_W-1:0] set_val;
		logic [ADDR_W-1:0] addr;
		settle_idle();
		apply_config(sb, ways, ob);
		idle_pct = pct;
		sb_eff = eff_set_bits();
		ways_eff = eff_ways();
		sh = int'(ob) + sb_eff;
		offset_mask = (64'd1 << ob) - 64'd1;
		tag_base = {$urandom, $urandom};
		repeat (count) begin
			if ($urandom_range(99) < 15) begin
				addr = {$urandom, $urandom};
			end else begin
				tag_val = tag_base + $urandom_range(0, ways_eff + 2);
				set_val = $urandom_range(1) ? $urandom_range(0, 1) :
					$urandom_range(0, (1 << sb_eff) - 1);
				addr = ({$urandom, $urandom} & offset_mask) | (set_val << ob);
				if (sh < ADDR_W)
					addr = addr | (tag_val << sh);
			end
			send_access(addr, $urandom_range(1) == 1);
		end
	endtask

	task automatic test_random_traffic();
		int sb_list [8] = '{0, 2, 7, 3, 6, 1, 4, 5};
		int ways_list [8] = '{1, 2, 15, 4, 0, 8, 8, 3};
		int ob_list [8] = '{0, 4, 6, 0, 63, 57, 2, 10};
		int pct_list [8] = '{16, 16, 16, 64, 64, 64, 0, 0};
		for (int p = 0; p < 8; p++)
			run_traffic_phase(6'(sb_list[p]), 6'(ways_list[p]), 6'(ob_list[p]),
				pct_list[p], 244);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: outcome %0d", result.outcome);
				failed = 1'b1;
			end else begin
				want = pending_results.pop_front();
				if (result.outcome !== want.outcome) begin
					$error("outcome: expected %0d, actual %0d", want.outcome, result.outcome);
					failed = 1'b1;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, result.last);
					failed = 1'b1;
				end
				if (result.hits_so_far !== want.hits_so_far) begin
					$error("hits_so_far: expected %0d, actual %0d",
						want.hits_so_far, result.hits_so_far);
					failed = 1'b1;
				end
				if (result.misses_so_far !== want.misses_so_far) begin
					$error("misses_so_far: expected %0d, actual %0d",
						want.misses_so_far, result.misses_so_far);
					failed = 1'b1;
				end
				if (result.evictions_so_far !== want.evictions_so_far) begin
					$error("evictions_so_far: expected %0d, actual %0d",
						want.evictions_so_far, result.evictions_so_far);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("tb_set_assoc_lru_cache_tag_store_unit NOT OK");
		$finish;
	end

	initial begin
		failed = 1'b0;
		idle_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		start = 1'b0;
		access = '0;
		for (int i = 0; i < LINES; i++) begin
			line_valid[i] = 1'b0;
			line_tag[i] = '0;
			line_stamp[i] = '0;
		end
		access_clock = '0;
		hit_tally = '0;
		miss_tally = '0;
		evict_tally = '0;
		cfg_set_bits = 3'd0;
		cfg_ways = 4'd1;
		cfg_offset_bits = 6'd0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_single_way();
		test_way_limit();
		test_wide_shifts();
		test_random_traffic();

		settle_idle();
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			failed = 1'b1;
		end
		if (!failed)
			$display("tb_set_assoc_lru_cache_tag_store_unit OK");
		else
			$display("tb_set_assoc_lru_cache_tag_store_unit NOT OK");
		$finish;
	end

endmodule
